// File: sv/sjgi_pkg.sv
// Shared types, constants and gap tables for the Shift-JIS glyph index core.
`default_nettype none

package sjgi_pkg;

   // Font geometry
   localparam int FONT_GLYPHS = 16384;
   localparam int GLYPH_W     = 14;
   localparam int GAP_COUNT   = 18;
   localparam int GAP_LEN_W   = 11;

   // Working width of the signed glyph number
   localparam int NUM_W = 18;
   localparam logic signed [NUM_W-1:0] FONT_LIMIT = NUM_W'(FONT_GLYPHS);

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_GAP   = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Conversion constants
   localparam logic [15:0] HIGH_AREA    = 16'hE000;
   localparam logic [15:0] HIGH_SHIFT   = 16'h4000;
   localparam logic [7:0]  LEAD_BASE    = 8'h81;
   localparam logic [7:0]  TRAIL_SPLIT  = 8'h9E;
   localparam logic [15:0] EVEN_ADJ     = 16'h0062;
   localparam logic [15:0] ODD_ADJ      = 16'h0040;
   localparam logic [15:0] EUC_OFFSET   = 16'hA1A1;   // 0x2121 + 0x8080
   localparam logic [7:0]  EUC_BASE     = 8'hA1;
   localparam int          ROW_CELLS    = 94;

   localparam logic [15:0] GAP_START [GAP_COUNT] = '{
      16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1,
      16'hA3BA, 16'hA3DB, 16'hA3FB, 16'hA4F4, 16'hA5F7, 16'hA6B9,
      16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
   };

   localparam logic [GAP_LEN_W-1:0] GAP_LEN [GAP_COUNT] = '{
      11'd11, 11'd8,  11'd11, 11'd7,  11'd4,   11'd15,
      11'd7,  11'd6,  11'd4,  11'd11, 11'd8,   11'd8,
      11'd38, 11'd15, 11'd13, 11'd720, 11'd43, 11'd1030
   };

   // Running total of gap lengths through each gap
   localparam logic [GAP_LEN_W-1:0] GAP_CUM [GAP_COUNT] = '{
      11'd11,  11'd19,  11'd30,  11'd37,  11'd41,  11'd56,
      11'd63,  11'd69,  11'd73,  11'd84,  11'd92,  11'd100,
      11'd138, 11'd153, 11'd166, 11'd886, 11'd929, 11'd1959
   };

   // Classified word passed from front to back
   typedef struct packed {
      logic [15:0]          euc_code;
      logic                 gap_hit;
      logic [GAP_COUNT-1:0] gap_below;   // code at or above each gap start
   } sjgi_item_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic nonempty;
   } sjgi_qstat_type;

endpackage

`default_nettype wire

// File: sv/sjis_to_glyph_index_core.sv
// An accepted word passes through the queue and the result register to rsp_.
// Throughput: one word per cycle without stalls; the front writes a two-entry
// queue, the back drains it to the result register, each side stalling alone.
// req_stall rises only when the queue is full (two words held behind a stall).
// Reset (synchronous, active high) empties the queue and drops rsp_valid;
// datapath registers are not reset.
`default_nettype none

module sjis_to_glyph_index_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_lead_byte,
   input  wire logic [7:0]                    req_trail_byte,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [15:0]                        rsp_euc_code,
   output logic [sjgi_pkg::GLYPH_W-1:0]       rsp_glyph_index,
   output logic [1:0]                         rsp_status
);

   sjgi_pkg::sjgi_item_type  front_item;
   sjgi_pkg::sjgi_item_type  head_item;
   sjgi_pkg::sjgi_qstat_type qstat;
   logic                     push;
   logic                     pop;

   // Front: pure conversion plus gap compare; result lands in the queue
   sjgi_front u_front (
      .lead_byte  (req_lead_byte),
      .trail_byte (req_trail_byte),
      .item       (front_item)
   );

   // Stall depends only on queue occupancy, never on req_valid
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   sjgi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // Back: index math, gap removal, range check, output register
   sjgi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_euc_code    (rsp_euc_code),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

// File: sv/sjgi_front.sv
// Front end: Shift-JIS to EUC-JP conversion and gap classification.
`default_nettype none

module sjgi_front (
   input  wire logic [7:0]            lead_byte,
   input  wire logic [7:0]            trail_byte,
   output sjgi_pkg::sjgi_item_type    item
);

   logic [15:0] sjis_code;
   logic [15:0] folded;
   logic [7:0]  row_off;
   logic [15:0] packed_code;
   logic [15:0] gap_free;
   logic [15:0] adjusted;
   logic [15:0] euc;
   logic [sjgi_pkg::GAP_COUNT-1:0] below;
   logic [sjgi_pkg::GAP_COUNT-1:0] in_gap;

   always_comb begin
      sjis_code = {lead_byte, trail_byte};
      if (sjis_code >= sjgi_pkg::HIGH_AREA) begin
         folded = sjis_code - sjgi_pkg::HIGH_SHIFT;
      end else begin
         folded = sjis_code;
      end
      row_off     = folded[15:8] - sjgi_pkg::LEAD_BASE;
      packed_code = {row_off[6:0], 1'b0, trail_byte};
      // skip the 0x7F hole in the trail range
      if (trail_byte[7]) begin
         gap_free = packed_code - 16'd1;
      end else begin
         gap_free = packed_code;
      end
      if (gap_free[7:0] >= sjgi_pkg::TRAIL_SPLIT) begin
         adjusted = gap_free + sjgi_pkg::EVEN_ADJ;
      end else begin
         adjusted = gap_free - sjgi_pkg::ODD_ADJ;
      end
      euc = adjusted + sjgi_pkg::EUC_OFFSET;
   end

   // Gaps are disjoint and sorted, so below is a thermometer code
   always_comb begin
      for (int k = 0; k < sjgi_pkg::GAP_COUNT; k++) begin
         below[k]  = euc >= sjgi_pkg::GAP_START[k];
         in_gap[k] = below[k] &&
                     (euc <= (sjgi_pkg::GAP_START[k] +
                              16'(sjgi_pkg::GAP_LEN[k]) - 16'd1));
      end
   end

   assign item.euc_code  = euc;
   assign item.gap_hit   = |in_gap;
   assign item.gap_below = below;

endmodule

`default_nettype wire

// File: sv/sjgi_queue.sv
// Two-entry queue between the classify front and the index back end.
`default_nettype none

module sjgi_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sjgi_pkg::sjgi_item_type push_item,
   input  wire logic                  pop,
   output sjgi_pkg::sjgi_item_type    head_item,
   output sjgi_pkg::sjgi_qstat_type   qstat
);

   sjgi_pkg::sjgi_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = slot_ff[rd_ptr_ff];
   assign qstat.full     = cnt_ff == 2'd2;
   assign qstat.nonempty = cnt_ff != 2'd0;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("queue count above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop)
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count did not grow on push");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step");
`endif

endmodule

`default_nettype wire

// File: sv/sjgi_back.sv
// Back end: glyph number, gap removal, range check and result register.
`default_nettype none

module sjgi_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sjgi_pkg::sjgi_item_type       head_item,
   input  wire sjgi_pkg::sjgi_qstat_type      qstat,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [15:0]                        rsp_euc_code,
   output logic [sjgi_pkg::GLYPH_W-1:0]       rsp_glyph_index,
   output logic [1:0]                         rsp_status
);

   localparam int NW = sjgi_pkg::NUM_W;

   logic [sjgi_pkg::GAP_COUNT:0]      below_ext;
   logic [sjgi_pkg::GAP_LEN_W-1:0]    gap_total;
   logic signed [NW-1:0]              row_s, col_s, num_s;
   logic [1:0]                        status;

   logic                              valid_ff, valid_in;
   logic [15:0]                       euc_ff, euc_in;
   logic [sjgi_pkg::GLYPH_W-1:0]      index_ff, index_in;
   logic [1:0]                        status_ff, status_in;

   // Highest gap passed selects the running total of lengths
   always_comb begin
      below_ext = {1'b0, head_item.gap_below};
      gap_total = '0;
      for (int k = 0; k < sjgi_pkg::GAP_COUNT; k++) begin
         if (below_ext[k] && !below_ext[k+1]) begin
            gap_total = gap_total | sjgi_pkg::GAP_CUM[k];
         end
      end
   end

   always_comb begin
      row_s = $signed({{(NW-8){1'b0}}, head_item.euc_code[15:8]})
              - $signed({{(NW-8){1'b0}}, sjgi_pkg::EUC_BASE});
      col_s = $signed({{(NW-8){1'b0}}, head_item.euc_code[7:0]})
              - $signed({{(NW-8){1'b0}}, sjgi_pkg::EUC_BASE});
      num_s = row_s * $signed(NW'(sjgi_pkg::ROW_CELLS)) + col_s
              - $signed({{(NW-sjgi_pkg::GAP_LEN_W){1'b0}}, gap_total});
      if (head_item.gap_hit) begin
         status = sjgi_pkg::STATUS_GAP;
      end else if (num_s < 0 || num_s >= sjgi_pkg::FONT_LIMIT) begin
         status = sjgi_pkg::STATUS_RANGE;
      end else begin
         status = sjgi_pkg::STATUS_OK;
      end
   end

   assign pop = qstat.nonempty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in  = valid_ff;
      euc_in    = euc_ff;
      index_in  = index_ff;
      status_in = status_ff;
      if (pop) begin
         valid_in  = 1'b1;
         euc_in    = head_item.euc_code;
         status_in = status;
         index_in  = (status == sjgi_pkg::STATUS_OK) ?
                     num_s[sjgi_pkg::GLYPH_W-1:0] : '0;
      end else if (!rsp_stall) begin
         valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      euc_ff    <= euc_in;
      index_ff  <= index_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_euc_code    = euc_ff;
   assign rsp_glyph_index = index_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

// File: bench/sjis_glyph_checker.sv
// Checker for the Shift-JIS glyph index core: predicts each result word and compares it.
`default_nettype none

module sjis_glyph_checker
   import sjgi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [7:0]          req_lead_byte,
   input  wire logic [7:0]          req_trail_byte,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [15:0]         rsp_euc_code,
   input  wire logic [GLYPH_W-1:0]  rsp_glyph_index,
   input  wire logic [1:0]          rsp_status,
   output int                       mismatches,
   output int                       outstanding,
   output int                       glyphs_ok,
   output int                       glyphs_gap,
   output int                       glyphs_range
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0]         euc_code;
      logic [GLYPH_W-1:0]  glyph_index;
      logic [1:0]          status;
   } glyph_word_t;

   // font gaps: first missing EUC code and number of missing codes
   localparam int N_GAPS = 18;
   localparam logic [15:0] MISSING_FIRST [N_GAPS] = '{
      16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1,
      16'hA3BA, 16'hA3DB, 16'hA3FB, 16'hA4F4, 16'hA5F7, 16'hA6B9,
      16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
   };
   localparam int MISSING_SIZE [N_GAPS] = '{
      11, 8, 11, 7, 4, 15, 7, 6, 4, 11, 8, 8, 38, 15, 13, 720, 43, 1030
   };

   glyph_word_t glyph_q[$];
   glyph_word_t want;

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      glyphs_ok    = 0;
      glyphs_gap   = 0;
      glyphs_range = 0;
   end

   function automatic glyph_word_t predict_glyph(input logic [7:0] lead, input logic [7:0] trail);
      logic [15:0]  code;
      logic [7:0]   row_off;
      int           num;
      int           gap_end;
      int           k;
      glyph_word_t  w;
      code = {lead, trail};
      if (code >= 16'hE000) code = code - 16'h4000;
      row_off = code[15:8] - 8'h81;
      code = {row_off[6:0], 1'b0, code[7:0]};
      // skip the 0x7F hole in the trail range
      if (code[7:0] >= 8'h80) code = code - 16'd1;
      if (code[7:0] >= 8'h9E) code = code + 16'h0062;
      else code = code - 16'h0040;
      code = code + 16'hA1A1;
      num = (int'(code[15:8]) - 161) * 94 + int'(code[7:0]) - 161;
      w.status = STATUS_OK;
      for (k = 0; k < N_GAPS; k++) begin
         if (code >= MISSING_FIRST[k]) begin
            gap_end = int'(MISSING_FIRST[k]) + MISSING_SIZE[k] - 1;
            if (int'(code) <= gap_end) begin
               w.status = STATUS_GAP;
               break;
            end
            num = num - MISSING_SIZE[k];
         end
      end
      if (w.status == STATUS_OK && (num < 0 || num >= FONT_GLYPHS)) w.status = STATUS_RANGE;
      w.euc_code    = code;
      w.glyph_index = (w.status == STATUS_OK) ? num[GLYPH_W-1:0] : '0;
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         glyph_q.delete();
         outstanding <= 0;
      end else begin
         // retire first so a word cannot be matched on the edge it went in
         if (rsp_valid && !rsp_stall) begin
            if (glyph_q.size() == 0) begin
               report_mismatch($sformatf("result word %h/%h/%h with nothing expected",
                                         rsp_euc_code, rsp_glyph_index, rsp_status));
            end else begin
               want = glyph_q.pop_front();
               if (rsp_euc_code !== want.euc_code)
                  report_mismatch($sformatf("euc_code %h, expected %h",
                                            rsp_euc_code, want.euc_code));
               if (rsp_glyph_index !== want.glyph_index)
                  report_mismatch($sformatf("glyph_index %0d, expected %0d (euc %h)",
                                            rsp_glyph_index, want.glyph_index, want.euc_code));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d (euc %h)",
                                            rsp_status, want.status, want.euc_code));
               case (want.status)
                  STATUS_OK:  glyphs_ok++;
                  STATUS_GAP: glyphs_gap++;
                  default:    glyphs_range++;
               endcase
            end
         end
         if (req_valid && !req_stall)
            glyph_q.push_back(predict_glyph(req_lead_byte, req_trail_byte));
         outstanding <= glyph_q.size();
      end
   end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Top of the glyph index bench: clock, reset, stimulus, flow-control phases and verdict.
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import sjgi_pkg::*;

   localparam int RANDOM_WORDS = 700;
   localparam int N_PHASES     = 4;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [7:0]          req_lead_byte  = 8'h00;
   logic [7:0]          req_trail_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [15:0]         rsp_euc_code;
   logic [GLYPH_W-1:0]  rsp_glyph_index;
   logic [1:0]          rsp_status;

   int mismatches;
   int outstanding;
   int glyphs_ok;
   int glyphs_gap;
   int glyphs_range;

   // percent chances, changed per phase
   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sjis_to_glyph_index_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_lead_byte   (req_lead_byte),
      .req_trail_byte  (req_trail_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_euc_code    (rsp_euc_code),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_status      (rsp_status)
   );

   sjis_glyph_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_lead_byte   (req_lead_byte),
      .req_trail_byte  (req_trail_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_euc_code    (rsp_euc_code),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_status      (rsp_status),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .glyphs_ok       (glyphs_ok),
      .glyphs_gap      (glyphs_gap),
      .glyphs_range    (glyphs_range)
   );

   // Receiver back-pressure: a fresh coin each cycle, so stalls land on
   // every position of the two-entry queue (empty, one held, full).
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // Present one word and hold it until the core takes it. Returns in the
   // time step of the accepting edge; the caller decides what valid does next,
   // so valid sees only one nonblocking write per step.
   task automatic send_char(input logic [7:0] lead, input logic [7:0] trail);
      req_valid      <= 1'b1;
      req_lead_byte  <= lead;
      req_trail_byte <= trail;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Sender gaps: idle a geometric number of cycles after each word.
   task automatic sender_gap();
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Hold off the sender until every expected result word is back.
   // The first clock lets the checker's count catch up with the last accept.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Random character. Mostly well-formed double-byte codes; a share aimed at
   // the lead bytes whose rows hold the font gaps; the rest raw byte noise.
   task automatic random_char(output logic [7:0] lead, output logic [7:0] trail);
      int    pick;
      logic [7:0] gap_leads [6];
      gap_leads = '{8'h81, 8'h82, 8'h83, 8'h84, 8'h98, 8'hEA};
      pick  = $urandom_range(0, 99);
      // legal trail 0x40..0xFC without the 0x7F hole
      trail = 8'($urandom_range(8'h40, 8'hFB));
      if (trail >= 8'h7F) trail = trail + 8'd1;
      if (pick < 55) begin
         if ($urandom_range(0, 1) == 0) lead = 8'($urandom_range(8'h81, 8'h9F));
         else lead = 8'($urandom_range(8'hE0, 8'hEF));
      end else if (pick < 78) begin
         lead = gap_leads[$urandom_range(0, 5)];
      end else begin
         lead  = 8'($urandom_range(0, 255));
         trail = 8'($urandom_range(0, 255));
      end
   endtask

   initial begin
      logic [7:0] lead;
      logic [7:0] trail;
      int         phase;
      int         n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed words, no idling on either side ---
      send_char(8'h81, 8'h40);   // first kanji-area code, index zero
      send_char(8'h00, 8'h00);   // not Shift-JIS, wraps to a negative index
      send_char(8'hFF, 8'hFF);   // all ones, above the high area
      send_char(8'h81, 8'h7E);   // last trail before the 0x7F hole
      send_char(8'h81, 8'h7F);   // the hole itself
      send_char(8'h81, 8'h80);   // first trail after the hole
      send_char(8'h81, 8'h9E);   // last odd-row trail
      send_char(8'h81, 8'h9F);   // first even-row trail
      send_char(8'h81, 8'hFC);   // last legal trail
      send_char(8'h81, 8'hAC);   // just below the first font gap
      send_char(8'h81, 8'hAD);   // first code of the first font gap
      send_char(8'h84, 8'h9F);   // first code of row 8, below the long gap
      send_char(8'h98, 8'h72);   // just below the row-47 gap
      send_char(8'h98, 8'h73);   // inside the row-47 gap
      send_char(8'h9F, 8'hFC);   // last code before the high area
      send_char(8'hDF, 8'hFF);   // just below the high-area split
      send_char(8'hE0, 8'h40);   // first high-area code
      send_char(8'hEA, 8'hA2);   // just below the top gap
      send_char(8'hEA, 8'hA3);   // first code of the top gap
      send_char(8'hEF, 8'hFC);   // last high-area code, above the top gap
      send_char(8'h7F, 8'h80);   // single-byte lead, out of range
      send_char(8'hA0, 8'h55);   // half-width lead, no check applied
      send_char(8'h55, 8'hAA);   // alternating bits
      send_char(8'hAA, 8'h55);
      drain();

      // --- random words over four flow-control phases ---
      // phase 0: full rate; 1: sender mostly idle; 2: receiver mostly stalled;
      // 3: light idling on both sides. Drain between phases so the core
      // goes empty with the sender held off.
      for (phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         for (n = 0; n < RANDOM_WORDS / N_PHASES; n++) begin
            random_char(lead, trail);
            send_char(lead, trail);
            sender_gap();
         end
         drain();
      end

      stall_pct = 0;
      // let any stray result words appear before the verdict
      repeat (6) @(posedge clock);

      $display("Sent %0d words (directed edges, then random under four stall/idle mixes).",
               sent);
      $display("Results seen: %0d ok, %0d in font gaps, %0d out of range.",
               glyphs_ok, glyphs_gap, glyphs_range);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: ends the run as failed if it never finishes.
   initial begin
      #200000;
      $display("Timeout with %0d result words still expected.", outstanding);
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
